// ===== src/jst_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// JSON tokenizer package
// Shared types, token codes, parser phases and character helpers.
// ----------------------------------------------------------------------------
package jst_pkg;

   localparam int STACK_DEPTH = 64;
   localparam int QUEUE_DEPTH = 4;
   localparam int QADDR_W     = $clog2(QUEUE_DEPTH);
   localparam int MAX_TOK     = 3;

   typedef enum logic [3:0] {
      K_OBJOPEN  = 4'd0,
      K_OBJCLOSE = 4'd1,
      K_ARROPEN  = 4'd2,
      K_ARRCLOSE = 4'd3,
      K_KEYBYTE  = 4'd4,
      K_KEYEND   = 4'd5,
      K_STRBYTE  = 4'd6,
      K_STREND   = 4'd7,
      K_NUMBYTE  = 4'd8,
      K_NUMEND   = 4'd9,
      K_NULL     = 4'd10,
      K_TRUE     = 4'd11,
      K_FALSE    = 4'd12,
      K_OK       = 4'd13,
      K_ERROR    = 4'd14
   } kind_type;

   typedef enum logic [17:0] {
      PH_VALUE     = 18'd1,
      PH_ARR_FIRST = 18'd2,
      PH_OBJ_FIRST = 18'd4,
      PH_KEY_NEXT  = 18'd8,
      PH_COLON     = 18'd16,
      PH_AFTER     = 18'd32,
      PH_STR       = 18'd64,
      PH_ESC       = 18'd128,
      PH_HEX       = 18'd256,
      PH_LIT       = 18'd512,
      PH_N_SIGN    = 18'd1024,
      PH_N_ZERO    = 18'd2048,
      PH_N_INT     = 18'd4096,
      PH_N_DOT     = 18'd8192,
      PH_N_FRAC    = 18'd16384,
      PH_N_EXP     = 18'd32768,
      PH_N_EXPSIGN = 18'd65536,
      PH_N_EXPDIG  = 18'd131072
   } phase_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
      logic [6:0] lvl;
   } tok_type;

   // all tokens caused by one accepted item
   typedef struct packed {
      logic [1:0]           n;
      tok_type [MAX_TOK-1:0] tok;
      logic [31:0]          off;
   } bundle_type;

   function automatic bundle_type add_tok(bundle_type b, kind_type k, logic [7:0] d,
                                          logic [6:0] l);
      bundle_type r;
      r = b;
      r.tok[b.n].kind = k;
      r.tok[b.n].data = d;
      r.tok[b.n].lvl  = l;
      r.n = b.n + 2'd1;
      return r;
   endfunction

   function automatic logic is_ws(logic [7:0] c);
      return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D;
   endfunction

   function automatic logic is_digit(logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic is_num(phase_type p);
      return p == PH_N_SIGN || p == PH_N_ZERO || p == PH_N_INT || p == PH_N_DOT ||
             p == PH_N_FRAC || p == PH_N_EXP || p == PH_N_EXPSIGN || p == PH_N_EXPDIG;
   endfunction

   function automatic logic num_complete(phase_type p);
      return p == PH_N_ZERO || p == PH_N_INT || p == PH_N_FRAC || p == PH_N_EXPDIG;
   endfunction

   // "nulltruefalse"
   function automatic logic [7:0] lit_char(logic [3:0] i);
      logic [7:0] r;
      case (i)
         4'd0:    r = "n";
         4'd1:    r = "u";
         4'd2:    r = "l";
         4'd3:    r = "l";
         4'd4:    r = "t";
         4'd5:    r = "r";
         4'd6:    r = "u";
         4'd7:    r = "e";
         4'd8:    r = "f";
         4'd9:    r = "a";
         4'd10:   r = "l";
         4'd11:   r = "s";
         4'd12:   r = "e";
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   // {valid, value}
   function automatic logic [4:0] hex_val(logic [7:0] c);
      logic [7:0] t;
      t = 8'h00;
      if (c >= 8'h30 && c <= 8'h39) begin
         t = c - 8'h30;
         return {1'b1, t[3:0]};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         t = c - 8'h57;
         return {1'b1, t[3:0]};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         t = c - 8'h37;
         return {1'b1, t[3:0]};
      end
      return 5'd0;
   endfunction

endpackage
`default_nettype wire

// ===== src/json_stream_tokenizer.sv =====
// A byte that yields tokens writes its bundle into the bundle queue; its tokens then
// pass one at a time through the output register to the result ports.
// Throughput: one byte per cycle in while the queue has room; one token per cycle out
// of the output register while the receiver pops, so a byte's tokens leave in turn.
// The front end stalls (req_full) only when the 4-entry bundle queue is full.
// Reset: synchronous, active high; clears the parser, queue and output register and
// sets max_nesting to 64. End of text also returns the parser to its reset state.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// JSON stream tokenizer
// Byte-in, token-out JSON tokenizer: front end parses, back end serializes.
// ----------------------------------------------------------------------------
module json_stream_tokenizer import jst_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [7:0]  req_char_code,
   input  wire logic        req_end_of_text,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [3:0]       rsp_token_kind,
   output logic [7:0]       rsp_token_byte,
   output logic [6:0]       rsp_nesting_level,
   output logic [31:0]      rsp_error_offset,
   output logic             rsp_last_of_run,
   input  wire logic        csr_we,
   input  wire logic [6:0]  csr_wdata
);

   logic [6:0] max_nesting_ff;
   logic       accept, q_full, q_empty, q_pop, b_valid;
   bundle_type b, head;

   // an item transfer happens whenever req_push is high and the queue has room
   assign accept   = req_push && !q_full;
   assign req_full = q_full;

   always_ff @(posedge clock) begin
      if (reset) max_nesting_ff <= 7'd64;
      else if (csr_we) max_nesting_ff <= csr_wdata;
   end

   // front: grammar check, stack, escapes; at most one bundle of up to three tokens per item
   jst_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .char_code    (req_char_code),
      .end_of_text  (req_end_of_text),
      .max_nesting  (max_nesting_ff),
      .bundle       (b),
      .bundle_valid (b_valid)
   );

   // decouples the parser from output backpressure
   jst_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (b_valid),
      .push_data (b),
      .pop       (q_pop),
      .full      (q_full),
      .empty     (q_empty),
      .head      (head)
   );

   // back: one token per transfer, last_of_run on the bundle's final token
   jst_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head              (head),
      .q_empty           (q_empty),
      .q_pop             (q_pop),
      .rsp_pop           (rsp_pop),
      .rsp_empty         (rsp_empty),
      .rsp_token_kind    (rsp_token_kind),
      .rsp_token_byte    (rsp_token_byte),
      .rsp_nesting_level (rsp_nesting_level),
      .rsp_error_offset  (rsp_error_offset),
      .rsp_last_of_run   (rsp_last_of_run)
   );

`ifndef ASSERT_OFF
   // a status token always closes its run
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && (rsp_token_kind == K_OK || rsp_token_kind == K_ERROR))
         |-> rsp_last_of_run)
      else $error("status token not last of run");

   // offset only carried by error tokens
   a_off_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_token_kind != K_ERROR) |-> rsp_error_offset == 32'd0)
      else $error("nonzero offset on non-error token");

   a_level: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> rsp_nesting_level <= 7'(STACK_DEPTH))
      else $error("nesting level above stack depth");
`endif

endmodule
`default_nettype wire

// ===== src/jst_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// JSON tokenizer front end
// Grammar state machine; turns each accepted item into a bundle of tokens.
// ----------------------------------------------------------------------------
module jst_front import jst_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       accept,
   input  wire logic [7:0] char_code,
   input  wire logic       end_of_text,
   input  wire logic [6:0] max_nesting,
   output bundle_type      bundle,
   output logic            bundle_valid
);

   phase_type   ph_ff, ph_in;
   logic [STACK_DEPTH-1:0] stack_ff, stack_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [3:0]  lit_ff, lit_in;
   logic [1:0]  hexn_ff, hexn_in;
   logic [15:0] hexacc_ff, hexacc_in;
   logic        key_ff, key_in;
   logic        failed_ff, failed_in;
   logic [31:0] failpos_ff, failpos_in;
   logic [31:0] bytepos_ff, bytepos_in;

   bundle_type  b;
   logic        go, fail_now, do_start, nok, top;
   phase_type   nph;
   logic [7:0]  c, d, limit;
   logic [4:0]  hv;
   logic [15:0] cp;

   assign c = char_code;

   always_comb begin
      ph_in = ph_ff; stack_in = stack_ff; cnt_in = cnt_ff; lit_in = lit_ff;
      hexn_in = hexn_ff; hexacc_in = hexacc_ff; key_in = key_ff;
      failed_in = failed_ff; failpos_in = failpos_ff; bytepos_in = bytepos_ff;
      b = '0; go = 1'b0; fail_now = 1'b0; do_start = 1'b0; nok = 1'b0; nph = ph_ff;
      top = stack_ff[0]; d = 8'h00; hv = 5'd0; cp = 16'd0;
      limit = (max_nesting < 7'(STACK_DEPTH)) ? {1'b0, max_nesting} : 8'(STACK_DEPTH);
      if (end_of_text) begin
         if (!failed_ff && num_complete(ph_ff)) begin
            b = add_tok(b, K_NUMEND, 8'h00, cnt_ff);
            ph_in = PH_AFTER;
         end
         if (!failed_ff && ph_in == PH_AFTER && cnt_ff == 7'd0) begin
            b = add_tok(b, K_OK, 8'h00, cnt_ff);
         end else begin
            b = add_tok(b, K_ERROR, 8'h00, cnt_ff);
            b.off = failed_ff ? failpos_ff : bytepos_ff;
         end
         ph_in = PH_VALUE; stack_in = '0; cnt_in = '0; lit_in = '0; hexn_in = '0;
         hexacc_in = '0; key_in = 1'b0; failed_in = 1'b0; failpos_in = '0;
         bytepos_in = '0;
      end else begin
         if (!failed_ff) begin
            go = 1'b1;
            if (is_num(ph_ff)) begin
               case (ph_ff)
                  PH_N_SIGN: if (is_digit(c)) begin
                     nok = 1'b1; nph = (c == "0") ? PH_N_ZERO : PH_N_INT;
                  end
                  PH_N_ZERO: begin
                     if (c == ".") begin nok = 1'b1; nph = PH_N_DOT; end
                     else if (c == "e" || c == "E") begin nok = 1'b1; nph = PH_N_EXP; end
                  end
                  PH_N_INT: begin
                     if (is_digit(c)) begin nok = 1'b1; nph = PH_N_INT; end
                     else if (c == ".") begin nok = 1'b1; nph = PH_N_DOT; end
                     else if (c == "e" || c == "E") begin nok = 1'b1; nph = PH_N_EXP; end
                  end
                  PH_N_DOT: if (is_digit(c)) begin nok = 1'b1; nph = PH_N_FRAC; end
                  PH_N_FRAC: begin
                     if (is_digit(c)) begin nok = 1'b1; nph = PH_N_FRAC; end
                     else if (c == "e" || c == "E") begin nok = 1'b1; nph = PH_N_EXP; end
                  end
                  PH_N_EXP: begin
                     if (c == "+" || c == "-") begin nok = 1'b1; nph = PH_N_EXPSIGN; end
                     else if (is_digit(c)) begin nok = 1'b1; nph = PH_N_EXPDIG; end
                  end
                  PH_N_EXPSIGN, PH_N_EXPDIG: if (is_digit(c)) begin
                     nok = 1'b1; nph = PH_N_EXPDIG;
                  end
                  default: nok = 1'b0;
               endcase
               if (nok) begin
                  b = add_tok(b, K_NUMBYTE, c, cnt_ff);
                  ph_in = nph; go = 1'b0;
               end else if (!num_complete(ph_ff)) begin
                  fail_now = 1'b1; go = 1'b0;
               end else begin
                  b = add_tok(b, K_NUMEND, 8'h00, cnt_ff);
                  ph_in = PH_AFTER;
               end
            end
            if (go) begin
               case (ph_in)
                  PH_VALUE: if (!is_ws(c)) do_start = 1'b1;
                  PH_ARR_FIRST: begin
                     if (c == "]") begin
                        cnt_in = cnt_ff - 7'd1; stack_in = {1'b0, stack_ff[STACK_DEPTH-1:1]};
                        b = add_tok(b, K_ARRCLOSE, 8'h00, cnt_in); ph_in = PH_AFTER;
                     end else if (!is_ws(c)) do_start = 1'b1;
                  end
                  PH_OBJ_FIRST, PH_KEY_NEXT: begin
                     if (is_ws(c)) begin
                        go = 1'b0;
                     end else if (c == "}" && ph_in == PH_OBJ_FIRST) begin
                        cnt_in = cnt_ff - 7'd1; stack_in = {1'b0, stack_ff[STACK_DEPTH-1:1]};
                        b = add_tok(b, K_OBJCLOSE, 8'h00, cnt_in); ph_in = PH_AFTER;
                     end else if (c == "\"") begin
                        key_in = 1'b1; ph_in = PH_STR;
                     end else fail_now = 1'b1;
                  end
                  PH_COLON: begin
                     if (c == ":") ph_in = PH_VALUE;
                     else if (!is_ws(c)) fail_now = 1'b1;
                  end
                  PH_AFTER: begin
                     if (is_ws(c)) begin
                        go = 1'b0;
                     end else if (cnt_ff == 7'd0) begin
                        fail_now = 1'b1;
                     end else if (c == ",") begin
                        ph_in = top ? PH_KEY_NEXT : PH_VALUE;
                     end else if ((c == "]" && !top) || (c == "}" && top)) begin
                        cnt_in = cnt_ff - 7'd1; stack_in = {1'b0, stack_ff[STACK_DEPTH-1:1]};
                        b = add_tok(b, top ? K_OBJCLOSE : K_ARRCLOSE, 8'h00, cnt_in);
                        ph_in = PH_AFTER;
                     end else fail_now = 1'b1;
                  end
                  PH_STR: begin
                     if (c == "\"") begin
                        b = add_tok(b, key_ff ? K_KEYEND : K_STREND, 8'h00, cnt_ff);
                        ph_in = key_ff ? PH_COLON : PH_AFTER;
                     end else if (c == "\\") begin
                        ph_in = PH_ESC;
                     end else begin
                        b = add_tok(b, key_ff ? K_KEYBYTE : K_STRBYTE, c, cnt_ff);
                     end
                  end
                  PH_ESC: begin
                     nok = 1'b1;
                     case (c)
                        "\"", "\\", "/": d = c;
                        "b":     d = 8'h08;
                        "f":     d = 8'h0C;
                        "n":     d = 8'h0A;
                        "r":     d = 8'h0D;
                        "t":     d = 8'h09;
                        default: nok = 1'b0;
                     endcase
                     if (nok) begin
                        b = add_tok(b, key_ff ? K_KEYBYTE : K_STRBYTE, d, cnt_ff);
                        ph_in = PH_STR;
                     end else if (c == "u") begin
                        hexn_in = 2'd0; hexacc_in = 16'd0; ph_in = PH_HEX;
                     end else fail_now = 1'b1;
                  end
                  PH_HEX: begin
                     hv = hex_val(c);
                     if (!hv[4]) begin
                        fail_now = 1'b1;
                     end else begin
                        cp = {hexacc_ff[11:0], hv[3:0]};
                        hexacc_in = cp;
                        if (hexn_ff == 2'd3) begin
                           hexn_in = 2'd0;
                           if (cp[15:11] == 5'b11011) begin
                              fail_now = 1'b1;
                           end else begin
                              if (cp[15:7] == 9'd0) begin
                                 b = add_tok(b, key_ff ? K_KEYBYTE : K_STRBYTE,
                                             {1'b0, cp[6:0]}, cnt_ff);
                              end else if (cp[15:11] == 5'd0) begin
                                 b = add_tok(b, key_ff ? K_KEYBYTE : K_STRBYTE,
                                             {3'b110, cp[10:6]}, cnt_ff);
                                 b = add_tok(b, key_ff ? K_KEYBYTE : K_STRBYTE,
                                             {2'b10, cp[5:0]}, cnt_ff);
                              end else begin
                                 b = add_tok(b, key_ff ? K_KEYBYTE : K_STRBYTE,
                                             {4'b1110, cp[15:12]}, cnt_ff);
                                 b = add_tok(b, key_ff ? K_KEYBYTE : K_STRBYTE,
                                             {2'b10, cp[11:6]}, cnt_ff);
                                 b = add_tok(b, key_ff ? K_KEYBYTE : K_STRBYTE,
                                             {2'b10, cp[5:0]}, cnt_ff);
                              end
                              ph_in = PH_STR;
                           end
                        end else begin
                           hexn_in = hexn_ff + 2'd1;
                        end
                     end
                  end
                  PH_LIT: begin
                     if (lit_ff > 4'd12 || c != lit_char(lit_ff)) begin
                        fail_now = 1'b1;
                     end else if (lit_ff == 4'd3 || lit_ff == 4'd7 || lit_ff == 4'd12) begin
                        b = add_tok(b, (lit_ff == 4'd3) ? K_NULL :
                                       (lit_ff == 4'd7) ? K_TRUE : K_FALSE, 8'h00, cnt_ff);
                        lit_in = 4'd0; ph_in = PH_AFTER;
                     end else begin
                        lit_in = lit_ff + 4'd1;
                     end
                  end
                  default: fail_now = 1'b1;
               endcase
            end
            if (do_start) begin
               if ({1'b0, cnt_ff} + 8'd1 > limit) begin
                  fail_now = 1'b1;
               end else if (c == "{" || c == "[") begin
                  stack_in = {stack_ff[STACK_DEPTH-2:0], c == "{"};
                  cnt_in = cnt_ff + 7'd1;
                  b = add_tok(b, (c == "{") ? K_OBJOPEN : K_ARROPEN, 8'h00, cnt_in);
                  ph_in = (c == "{") ? PH_OBJ_FIRST : PH_ARR_FIRST;
               end else if (c == "\"") begin
                  key_in = 1'b0; ph_in = PH_STR;
               end else if (c == "n" || c == "t" || c == "f") begin
                  lit_in = (c == "n") ? 4'd1 : (c == "t") ? 4'd5 : 4'd9;
                  ph_in = PH_LIT;
               end else if (c == "-" || is_digit(c)) begin
                  b = add_tok(b, K_NUMBYTE, c, cnt_ff);
                  ph_in = (c == "-") ? PH_N_SIGN : (c == "0") ? PH_N_ZERO : PH_N_INT;
               end else fail_now = 1'b1;
            end
            if (fail_now) begin
               failed_in = 1'b1; failpos_in = bytepos_ff;
            end
         end
         if (bytepos_ff != 32'hFFFF_FFFF) bytepos_in = bytepos_ff + 32'd1;
      end
   end

   assign bundle       = b;
   assign bundle_valid = accept && (b.n != 2'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff <= PH_VALUE; stack_ff <= '0; cnt_ff <= '0; lit_ff <= '0; hexn_ff <= '0;
         hexacc_ff <= '0; key_ff <= 1'b0; failed_ff <= 1'b0; failpos_ff <= '0;
         bytepos_ff <= '0;
      end else if (accept) begin
         ph_ff <= ph_in; stack_ff <= stack_in; cnt_ff <= cnt_in; lit_ff <= lit_in;
         hexn_ff <= hexn_in; hexacc_ff <= hexacc_in; key_ff <= key_in;
         failed_ff <= failed_in; failpos_ff <= failpos_in; bytepos_ff <= bytepos_in;
      end
   end

endmodule
`default_nettype wire

// ===== src/jst_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// JSON tokenizer bundle queue
// Short queue of token bundles between front end and back end.
// ----------------------------------------------------------------------------
module jst_fifo import jst_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  push,
   input  bundle_type push_data,
   input  wire logic  pop,
   output logic       full,
   output logic       empty,
   output bundle_type head
);

   bundle_type mem [QUEUE_DEPTH];
   logic [QADDR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [QADDR_W:0]   cnt_ff, cnt_in;

   assign full  = cnt_ff == (QADDR_W + 1)'(QUEUE_DEPTH);
   assign empty = cnt_ff == '0;
   assign head  = mem[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + QADDR_W'(1) : wr_ff;
      rd_in  = pop  ? rd_ff + QADDR_W'(1) : rd_ff;
      cnt_in = cnt_ff + (QADDR_W + 1)'(push) - (QADDR_W + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) mem[wr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0; rd_ff <= '0; cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in; rd_ff <= rd_in; cnt_ff <= cnt_in;
      end
   end

endmodule
`default_nettype wire

// ===== src/jst_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// JSON tokenizer back end
// Splits queued bundles into single tokens held in an output register.
// ----------------------------------------------------------------------------
module jst_back import jst_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   input  bundle_type  head,
   input  wire logic   q_empty,
   output logic        q_pop,
   input  wire logic   rsp_pop,
   output logic        rsp_empty,
   output logic [3:0]  rsp_token_kind,
   output logic [7:0]  rsp_token_byte,
   output logic [6:0]  rsp_nesting_level,
   output logic [31:0] rsp_error_offset,
   output logic        rsp_last_of_run
);

   logic        valid_ff, valid_in;
   logic [1:0]  idx_ff, idx_in;
   tok_type     tok_ff, tok_in;
   logic [31:0] off_ff, off_in;
   logic        last_ff, last_in;
   logic        load, is_last;

   assign load    = !valid_ff || rsp_pop;
   assign is_last = idx_ff == head.n - 2'd1;

   always_comb begin
      valid_in = valid_ff; idx_in = idx_ff; tok_in = tok_ff; off_in = off_ff;
      last_in = last_ff; q_pop = 1'b0;
      if (load) begin
         valid_in = !q_empty;
         if (!q_empty) begin
            tok_in  = head.tok[idx_ff];
            off_in  = (head.tok[idx_ff].kind == K_ERROR) ? head.off : 32'd0;
            last_in = is_last;
            q_pop   = is_last;
            idx_in  = is_last ? 2'd0 : idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0; idx_ff <= 2'd0;
      end else begin
         valid_ff <= valid_in; idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      tok_ff <= tok_in; off_ff <= off_in; last_ff <= last_in;
   end

   assign rsp_empty         = !valid_ff;
   assign rsp_token_kind    = tok_ff.kind;
   assign rsp_token_byte    = tok_ff.data;
   assign rsp_nesting_level = tok_ff.lvl;
   assign rsp_error_offset  = off_ff;
   assign rsp_last_of_run   = last_ff;

endmodule
`default_nettype wire

// ===== sim/json_stream_tokenizer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON stream tokenizer testbench
// Streams directed and random JSON texts through the tokenizer, predicts
// the token stream with a behavioral parser and checks every token transfer.
// Covers nesting limits, number syntax, escapes, errors and backpressure.
// ----------------------------------------------------------------------------
module json_stream_tokenizer_tb;
   import jst_pkg::*;

   localparam int CYCLE_LIMIT = 300000;
   localparam int SETTLE_CYCLES = 10;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [7:0]  req_char_code = 8'h00;
   logic        req_end_of_text = 1'b0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [3:0]  rsp_token_kind;
   logic [7:0]  rsp_token_byte;
   logic [6:0]  rsp_nesting_level;
   logic [31:0] rsp_error_offset;
   logic        rsp_last_of_run;
   logic        csr_we = 1'b0;
   logic [6:0]  csr_wdata = 7'd0;

   json_stream_tokenizer dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full),
      .req_char_code(req_char_code), .req_end_of_text(req_end_of_text),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
      .rsp_token_kind(rsp_token_kind), .rsp_token_byte(rsp_token_byte),
      .rsp_nesting_level(rsp_nesting_level), .rsp_error_offset(rsp_error_offset),
      .rsp_last_of_run(rsp_last_of_run),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // expected token of one result transfer
   typedef struct {
      kind_type    kind;
      logic [7:0]  data;
      logic [6:0]  lvl;
      logic [31:0] off;
      logic        last;
   } token_type;

   token_type token_q[$];     // tokens still owed by the block, oldest first
   token_type item_toks[$];   // tokens caused by the byte being parsed
   int     fail_count = 0;
   int     items_sent = 0;
   int     send_idle_pct = 0;
   int     recv_stall_pct = 0;
   int     hold_off = 0;    // long receiver hold-off, counted in the receiver
   longint cycle_count = 0;
   byte    doc[$];         // random text under construction

   // ---------------------------------------------------------------------
   // Parser shadow state
   // ---------------------------------------------------------------------
   phase_type   phase;
   logic [63:0] kinds;      // 1 = object, 0 = array, per open level
   int          depth;
   int          lit_pos;
   int          hex_cnt;
   logic [15:0] hex_acc;
   logic        in_key;
   logic        failed;
   logic [31:0] fail_pos;
   logic [31:0] byte_pos;
   logic [6:0]  nest_limit = 7'd64;

   function automatic bit is_space(logic [7:0] c);
      return c == " " || c == 8'h09 || c == 8'h0A || c == 8'h0D;
   endfunction

   function automatic bit is_dec(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit num_done(phase_type p);
      return p == PH_N_ZERO || p == PH_N_INT || p == PH_N_FRAC || p == PH_N_EXPDIG;
   endfunction

   function automatic void clear_state();
      phase = PH_VALUE;
      kinds = '0;
      depth = 0;
      lit_pos = 0;
      hex_cnt = 0;
      hex_acc = '0;
      in_key = 1'b0;
      failed = 1'b0;
      fail_pos = '0;
      byte_pos = '0;
   endfunction

   function automatic void put_tok(kind_type k, logic [7:0] d, logic [31:0] off);
      token_type t;
      if (item_toks.size() >= 3) return;
      t.kind = k;
      t.data = d;
      t.lvl = depth[6:0];
      t.off = off;
      t.last = 1'b0;
      item_toks.push_back(t);
   endfunction

   function automatic void mark_fail();
      if (!failed) begin
         failed = 1'b1;
         fail_pos = byte_pos;
      end
   endfunction

   function automatic void text_byte(logic [7:0] b);
      put_tok(in_key ? K_KEYBYTE : K_STRBYTE, b, '0);
   endfunction

   function automatic void open_value(logic [7:0] c);
      int lim;
      lim = (nest_limit < 64) ? nest_limit : 64;
      if (depth + 1 > lim) begin
         mark_fail();
         return;
      end
      if (c == "{" || c == "[") begin
         kinds[depth] = (c == "{");
         depth++;
         put_tok(c == "{" ? K_OBJOPEN : K_ARROPEN, 8'h00, '0);
         phase = (c == "{") ? PH_OBJ_FIRST : PH_ARR_FIRST;
      end else if (c == "\"") begin
         in_key = 1'b0;
         phase = PH_STR;
      end else if (c == "n" || c == "t" || c == "f") begin
         lit_pos = (c == "n") ? 1 : (c == "t") ? 5 : 9;
         phase = PH_LIT;
      end else if (c == "-" || is_dec(c)) begin
         put_tok(K_NUMBYTE, c, '0);
         phase = (c == "-") ? PH_N_SIGN : (c == "0") ? PH_N_ZERO : PH_N_INT;
      end else begin
         mark_fail();
      end
   endfunction

   function automatic void close_level(bit obj);
      depth--;
      put_tok(obj ? K_OBJCLOSE : K_ARRCLOSE, 8'h00, '0);
      phase = PH_AFTER;
   endfunction

   // returns 1 when the byte was consumed by the number
   function automatic bit number_step(logic [7:0] c);
      phase_type nxt;
      bit ok, e;
      ok = 1'b0;
      nxt = phase;
      e = (c == "e" || c == "E");
      case (phase)
         PH_N_SIGN: if (is_dec(c)) begin
            ok = 1; nxt = (c == "0") ? PH_N_ZERO : PH_N_INT;
         end
         PH_N_ZERO: begin
            if (c == ".") begin ok = 1; nxt = PH_N_DOT; end
            else if (e) begin ok = 1; nxt = PH_N_EXP; end
         end
         PH_N_INT: begin
            if (is_dec(c)) begin ok = 1; nxt = PH_N_INT; end
            else if (c == ".") begin ok = 1; nxt = PH_N_DOT; end
            else if (e) begin ok = 1; nxt = PH_N_EXP; end
         end
         PH_N_DOT: if (is_dec(c)) begin ok = 1; nxt = PH_N_FRAC; end
         PH_N_FRAC: begin
            if (is_dec(c)) begin ok = 1; nxt = PH_N_FRAC; end
            else if (e) begin ok = 1; nxt = PH_N_EXP; end
         end
         PH_N_EXP: begin
            if (c == "+" || c == "-") begin ok = 1; nxt = PH_N_EXPSIGN; end
            else if (is_dec(c)) begin ok = 1; nxt = PH_N_EXPDIG; end
         end
         default: if (is_dec(c)) begin ok = 1; nxt = PH_N_EXPDIG; end
      endcase
      if (ok) begin
         put_tok(K_NUMBYTE, c, '0);
         phase = nxt;
         return 1'b1;
      end
      if (!num_done(phase)) begin
         mark_fail();
         return 1'b1;
      end
      put_tok(K_NUMEND, 8'h00, '0);
      phase = PH_AFTER;
      return 1'b0;
   endfunction

   function automatic void unicode_out();
      logic [15:0] cp;
      cp = hex_acc;
      if (cp >= 16'hD800 && cp <= 16'hDFFF) begin
         mark_fail();
         return;
      end
      if (cp < 16'h80) begin
         text_byte(cp[7:0]);
      end else if (cp < 16'h800) begin
         text_byte(8'hC0 | cp[15:6]);
         text_byte(8'h80 | cp[5:0]);
      end else begin
         text_byte(8'hE0 | cp[15:12]);
         text_byte(8'h80 | cp[11:6]);
         text_byte(8'h80 | cp[5:0]);
      end
      phase = PH_STR;
   endfunction

   function automatic void parse_byte(logic [7:0] c);
      string words;
      bit top;
      logic [8:0] d;
      logic [3:0] v;
      words = "nulltruefalse";
      if (phase >= PH_N_SIGN && number_step(c)) return;
      top = (depth > 0) ? kinds[depth-1] : 1'b0;
      case (phase)
         PH_VALUE: if (!is_space(c)) open_value(c);
         PH_ARR_FIRST: if (!is_space(c)) begin
            if (c == "]") close_level(0);
            else open_value(c);
         end
         PH_OBJ_FIRST, PH_KEY_NEXT: if (!is_space(c)) begin
            if (c == "}" && phase == PH_OBJ_FIRST) close_level(1);
            else if (c == "\"") begin in_key = 1'b1; phase = PH_STR; end
            else mark_fail();
         end
         PH_COLON: if (!is_space(c)) begin
            if (c == ":") phase = PH_VALUE;
            else mark_fail();
         end
         PH_AFTER: if (!is_space(c)) begin
            if (depth == 0) mark_fail();
            else if (c == ",") phase = top ? PH_KEY_NEXT : PH_VALUE;
            else if (c == "]" && !top) close_level(0);
            else if (c == "}" && top) close_level(1);
            else mark_fail();
         end
         PH_STR: begin
            if (c == "\"") begin
               put_tok(in_key ? K_KEYEND : K_STREND, 8'h00, '0);
               phase = in_key ? PH_COLON : PH_AFTER;
            end else if (c == "\\") begin
               phase = PH_ESC;
            end else begin
               text_byte(c);
            end
         end
         PH_ESC: begin
            d = 9'h100;
            if (c == "\"" || c == "\\" || c == "/") d = c;
            else if (c == "b") d = 9'h08;
            else if (c == "f") d = 9'h0C;
            else if (c == "n") d = 9'h0A;
            else if (c == "r") d = 9'h0D;
            else if (c == "t") d = 9'h09;
            if (!d[8]) begin
               text_byte(d[7:0]);
               phase = PH_STR;
            end else if (c == "u") begin
               hex_cnt = 0;
               hex_acc = '0;
               phase = PH_HEX;
            end else begin
               mark_fail();
            end
         end
         PH_HEX: begin
            if (is_dec(c)) v = c - "0";
            else if (c >= "a" && c <= "f") v = c - "a" + 10;
            else if (c >= "A" && c <= "F") v = c - "A" + 10;
            else begin
               mark_fail();
               return;
            end
            hex_acc = {hex_acc[11:0], v};
            if (hex_cnt >= 3) begin
               hex_cnt = 0;
               unicode_out();
            end else begin
               hex_cnt++;
            end
         end
         default: begin
            // literal: walk the word table, emit on the last letter
            if (lit_pos > 12 || c != words[lit_pos]) begin
               mark_fail();
            end else if (lit_pos == 3 || lit_pos == 7 || lit_pos == 12) begin
               put_tok(lit_pos == 3 ? K_NULL : lit_pos == 7 ? K_TRUE : K_FALSE, 8'h00, '0);
               lit_pos = 0;
               phase = PH_AFTER;
            end else begin
               lit_pos++;
            end
         end
      endcase
   endfunction

   // Predict all tokens of one accepted transfer and queue them.
   function automatic void predict_tokens(logic [7:0] c, logic eot);
      item_toks.delete();
      if (eot) begin
         if (!failed && num_done(phase)) begin
            put_tok(K_NUMEND, 8'h00, '0);
            phase = PH_AFTER;
         end
         if (!failed && phase == PH_AFTER && depth == 0) begin
            put_tok(K_OK, 8'h00, '0);
         end else begin
            mark_fail();
            put_tok(K_ERROR, 8'h00, fail_pos);
         end
         clear_state();
      end else begin
         if (!failed) parse_byte(c);
         if (byte_pos != 32'hFFFF_FFFF) byte_pos++;
      end
      if (item_toks.size() > 0) item_toks[item_toks.size()-1].last = 1'b1;
      foreach (item_toks[i]) token_q.push_back(item_toks[i]);
   endfunction

   // ---------------------------------------------------------------------
   // Input side
   // ---------------------------------------------------------------------
   // One byte transfer; push stays high afterward so back-to-back bytes
   // need no toggling. Random idle cycles drop push first.
   task automatic send_byte(logic [7:0] c, logic eot);
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_push <= 1'b1;
      req_char_code <= c;
      req_end_of_text <= eot;
      @(posedge clock);
      while (req_full) @(posedge clock);
      predict_tokens(c, eot);
      items_sent++;
   endtask

   task automatic send_text(string s);
      foreach (s[i]) send_byte(s[i], 1'b0);
   endtask

   // char code is don't-care with end of text; randomize it anyway
   task automatic end_text();
      send_byte(8'($urandom), 1'b1);
   endtask

   // Wait until every owed token has been popped, then let the pipe drain.
   task automatic drain();
      req_push <= 1'b0;
      while (token_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(logic [6:0] v);
      drain();
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      csr_wdata <= 7'($urandom);
      nest_limit = v;
   endtask

   // ---------------------------------------------------------------------
   // Output side: pop at random, check each transfer against the oldest
   // expected token.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      token_type t;
      if (!reset) begin
         if (rsp_pop && !rsp_empty) begin
            if (token_q.size() == 0) begin
               $error("unexpected token transfer: kind %0d", rsp_token_kind);
               fail_count++;
            end else begin
               t = token_q.pop_front();
               if (rsp_token_kind !== t.kind) begin
                  $error("token_kind: expected %0d, got %0d", t.kind, rsp_token_kind);
                  fail_count++;
               end
               if (rsp_token_byte !== t.data) begin
                  $error("token_byte: expected %0h, got %0h", t.data, rsp_token_byte);
                  fail_count++;
               end
               if (rsp_nesting_level !== t.lvl) begin
                  $error("nesting_level: expected %0d, got %0d", t.lvl, rsp_nesting_level);
                  fail_count++;
               end
               if (rsp_error_offset !== t.off) begin
                  $error("error_offset: expected %0d, got %0d", t.off, rsp_error_offset);
                  fail_count++;
               end
               if (rsp_last_of_run !== t.last) begin
                  $error("last_of_run: expected %0b, got %0b", t.last, rsp_last_of_run);
                  fail_count++;
               end
            end
         end
      end
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Random text generator: mostly well-formed values, nested a few deep
   // ---------------------------------------------------------------------
   function automatic void add_ws();
      byte sp[4] = '{8'h20, 8'h09, 8'h0A, 8'h0D};
      if ($urandom_range(3) == 0) doc.push_back(sp[$urandom_range(3)]);
   endfunction

   function automatic void add_digits(int lo);
      int n;
      n = $urandom_range(3, lo);
      repeat (n) doc.push_back("0" + $urandom_range(9));
   endfunction

   function automatic void add_string();
      string hx;
      string esc;
      hx = "0123456789abcdefABCDEF";
      esc = "\"\\/bfnrt";
      doc.push_back("\"");
      repeat ($urandom_range(3)) begin
         case ($urandom_range(9))
            0: begin
               doc.push_back("\\");
               doc.push_back(esc[$urandom_range(7)]);
            end
            1: begin
               doc.push_back("\\");
               doc.push_back("u");
               // bias toward 1, 2 and 3 byte encodings, some surrogates
               case ($urandom_range(4))
                  0: doc.push_back("0");
                  1: doc.push_back("d");
                  default: doc.push_back(hx[$urandom_range(21)]);
               endcase
               repeat (3) doc.push_back(hx[$urandom_range(21)]);
            end
            2: doc.push_back($urandom_range(8'h1F));
            3: doc.push_back($urandom_range(255, 128));
            default: doc.push_back($urandom_range(126, 32) == "\\" ? "a" :
                                   $urandom_range(126, 35));
         endcase
      end
      doc.push_back("\"");
   endfunction

   function automatic void add_number();
      if ($urandom_range(1)) doc.push_back("-");
      if ($urandom_range(3) == 0) doc.push_back("0");
      else begin
         doc.push_back("1" + $urandom_range(8));
         add_digits(0);
      end
      if ($urandom_range(2) == 0) begin
         doc.push_back(".");
         add_digits(1);
      end
      if ($urandom_range(2) == 0) begin
         doc.push_back($urandom_range(1) ? "e" : "E");
         case ($urandom_range(2))
            0: doc.push_back("+");
            1: doc.push_back("-");
            default: ;
         endcase
         add_digits(1);
      end
   endfunction

   function automatic void add_value(int lvl);
      string w;
      int n;
      add_ws();
      case ((lvl < 4) ? $urandom_range(6) : $urandom_range(4))
         0: add_string();
         1: add_number();
         2: begin
            if ($urandom_range(1)) w = "true";
            else if ($urandom_range(1)) w = "null";
            else w = "false";
            foreach (w[i]) doc.push_back(w[i]);
         end
         3: add_number();
         4: add_string();
         5: begin
            doc.push_back("[");
            n = $urandom_range(3);
            for (int i = 0; i < n; i++) begin
               if (i > 0) doc.push_back(",");
               add_value(lvl + 1);
            end
            add_ws();
            doc.push_back("]");
         end
         default: begin
            doc.push_back("{");
            n = $urandom_range(2);
            for (int i = 0; i < n; i++) begin
               if (i > 0) doc.push_back(",");
               add_ws();
               add_string();
               add_ws();
               doc.push_back(":");
               add_value(lvl + 1);
            end
            add_ws();
            doc.push_back("}");
         end
      endcase
      add_ws();
   endfunction

   task automatic send_random_doc();
      int k;
      doc.delete();
      add_value(0);
      k = $urandom_range(9);
      // a minority gets corrupted or cut short
      if (k == 0) doc[$urandom_range(doc.size() - 1)] = $urandom;
      else if (k == 1 && doc.size() > 1) doc = doc[0:$urandom_range(doc.size() - 2)];
      else if (k == 2) doc.push_back("0" + $urandom_range(9));
      foreach (doc[i]) send_byte(doc[i], 1'b0);
      end_text();
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   task automatic test_values();
      send_text("[null,true,false,{}]");
      end_text();
      send_text("{\"k\":-0.5e+3}");
      end_text();
   endtask

   task automatic test_strings();
      // a named escape, \u to 1/2/3 bytes, \u0000, raw zero and high bytes
      send_text("\"\\n\\u00e9\\u20AC\\u0000");
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_text("\"");
      end_text();
      send_text("\"\\ud800\"");   // surrogate
      end_text();
   endtask

   task automatic test_errors();
      end_text();               // empty text
      send_text("01");          // digit after a leading zero
      end_text();
      send_text("7 x");         // trailing garbage
      end_text();
      send_byte(8'h00, 1'b0);   // zero byte outside a string
      end_text();
      send_text("[5]");         // number closed by a bracket
      end_text();
   endtask

   task automatic test_nesting();
      write_limit(7'd1);
      send_text("[1]");
      end_text();
      write_limit(7'd0);        // nothing may start
      send_text("3");
      end_text();
      write_limit(7'd127);      // capped at stack depth
      repeat (64) send_byte("[", 1'b0);
      send_byte("[", 1'b0);     // one past the stack
      end_text();
      write_limit(7'd64);
   endtask

   task automatic test_backpressure();
      hold_off = 200;
      repeat (12) send_byte("[", 1'b0);
      repeat (12) send_byte("]", 1'b0);
      end_text();
      drain();
   endtask

   task automatic test_random();
      int modes[4][2] = '{'{0, 0}, '{64, 0}, '{0, 64}, '{8, 8}};
      int goal;
      goal = items_sent + 48;
      for (int m = 0; m < 4; m++) begin
         send_idle_pct = modes[m][0];
         recv_stall_pct = modes[m][1];
         write_limit($urandom_range(1) ? $urandom_range(5, 1) : 7'd64);
         while (items_sent < goal - (3 - m) * 12) send_random_doc();
      end
      send_idle_pct = 0;
      recv_stall_pct = 0;
      write_limit(7'd64);
   endtask

   initial begin
      clear_state();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_values();
      test_strings();
      test_errors();
      test_nesting();
      test_backpressure();
      test_random();
      drain();
      repeat (20) @(posedge clock);
      if (fail_count == 0 && token_q.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/jst_pkg.sv
src/jst_front.sv
src/jst_fifo.sv
src/jst_back.sv
src/json_stream_tokenizer.sv
sim/json_stream_tokenizer_tb.sv
